@@ sv/dbm_pkg.sv @@
// Shared types, constants and character decode functions for the dollar bracket matcher.
// No dependencies; every other file in sv/ refers to this package by scoped names.
`timescale 1ns / 1ps

package dbm_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int LEN_W       = 16;
    localparam int CHAR_W      = 8;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    typedef logic [1:0] code_t;

    localparam code_t CODE_NONE   = 2'd0;
    localparam code_t CODE_BRACE  = 2'd1;
    localparam code_t CODE_SQUARE = 2'd2;
    localparam code_t CODE_PAREN  = 2'd3;

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [CHAR_W-1:0] CH_LBRACE  = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE  = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_LSQUARE = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RSQUARE = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_DOLLAR  = 2'd1,
        PH_BRACKET = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_BUSY       = 3'd0,
        ST_NOT_DOLLAR = 3'd1,
        ST_PLAIN      = 3'd2,
        ST_BRACKETED  = 3'd3,
        ST_EOF        = 3'd4,
        ST_MISMATCH   = 3'd5,
        ST_OVERFLOW   = 3'd6
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [CHAR_W-1:0]    expected_close;
        logic [LEN_W-1:0]     token_length;
    } result_t;

    // push shifts the chain away from the top, pop shifts it towards the top
    typedef struct packed {
        logic  push;
        logic  pop;
        code_t code;
    } stack_op_t;

    function automatic code_t opener_code(input logic [CHAR_W-1:0] ch);
        code_t c;
        case (ch)
            CH_LBRACE:  c = CODE_BRACE;
            CH_LSQUARE: c = CODE_SQUARE;
            CH_LPAREN:  c = CODE_PAREN;
            default:    c = CODE_NONE;
        endcase
        return c;
    endfunction

    function automatic code_t closer_code(input logic [CHAR_W-1:0] ch);
        code_t c;
        case (ch)
            CH_RBRACE:  c = CODE_BRACE;
            CH_RSQUARE: c = CODE_SQUARE;
            CH_RPAREN:  c = CODE_PAREN;
            default:    c = CODE_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] closer_ascii(input code_t c);
        logic [CHAR_W-1:0] a;
        case (c)
            CODE_BRACE:  a = CH_RBRACE;
            CODE_SQUARE: a = CH_RSQUARE;
            CODE_PAREN:  a = CH_RPAREN;
            default:     a = CH_NUL;
        endcase
        return a;
    endfunction

endpackage

@@ sv/dbm_ifs.sv @@
// Valid/ready channel interfaces: source characters in, match results out.
// Depends on dbm_pkg for field widths and the status type.
`timescale 1ns / 1ps

interface dbm_char_if;
    logic                        valid;
    logic                        ready;
    logic [dbm_pkg::CHAR_W-1:0]  character;
    logic                        end_of_input;

    modport source (output valid, output character, output end_of_input, input ready);
    modport sink   (input valid, input character, input end_of_input, output ready);
endinterface

interface dbm_result_if;
    logic                        valid;
    logic                        ready;
    dbm_pkg::status_t            status;
    logic [dbm_pkg::CHAR_W-1:0]  expected_close;
    logic [dbm_pkg::LEN_W-1:0]   token_length;

    modport source (output valid, output status, output expected_close, output token_length,
                    input ready);
    modport sink   (input valid, input status, input expected_close, input token_length,
                    output ready);
endinterface

@@ sv/dbm_cell.sv @@
// One entry of the closer stack: holds a closer code, loads from its neighbours.
// Depends on dbm_pkg for code_t and stack_op_t.
`timescale 1ns / 1ps

module dbm_cell (
    input  logic               clk,
    input  dbm_pkg::stack_op_t op,
    input  dbm_pkg::code_t     from_up,
    input  dbm_pkg::code_t     from_down,
    output dbm_pkg::code_t     code
);

    dbm_pkg::code_t code_reg;

    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            code_reg <= from_up;
        end
        else if (op.pop)
        begin
            code_reg <= from_down;
        end
    end

    assign code = code_reg;

endmodule

@@ sv/dbm_stack.sv @@
// Closer stack as a chain of dbm_cell entries; cell 0 is the top of stack.
// Depends on dbm_pkg and dbm_cell.
`timescale 1ns / 1ps

module dbm_stack (
    input  logic               clk,
    input  dbm_pkg::stack_op_t op,
    output dbm_pkg::code_t     top
);

    dbm_pkg::code_t codes [dbm_pkg::STACK_DEPTH];

    genvar i;
    generate
        for (i = 0; i < dbm_pkg::STACK_DEPTH; i++)
        begin : g_cell
            dbm_pkg::code_t up;
            dbm_pkg::code_t down;

            if (i == 0)
            begin : g_first
                assign up = op.code;
            end
            else
            begin : g_mid_up
                assign up = codes[i-1];
            end

            if (i == dbm_pkg::STACK_DEPTH - 1)
            begin : g_last
                assign down = dbm_pkg::CODE_NONE;
            end
            else
            begin : g_mid_down
                assign down = codes[i+1];
            end

            dbm_cell u_cell (
                .clk       (clk),
                .op        (op),
                .from_up   (up),
                .from_down (down),
                .code      (codes[i])
            );
        end
    endgenerate

    assign top = codes[0];

endmodule

@@ sv/dbm_skid.sv @@
// Two-word output stage: result register plus skid register towards the result channel.
// Depends on dbm_pkg (result_t) and dbm_ifs (dbm_result_if).
`timescale 1ns / 1ps

module dbm_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              word_valid,
    input  dbm_pkg::result_t  word,
    output logic              word_ready,
    dbm_result_if.source      result
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    dbm_pkg::result_t  out_word_reg;
    dbm_pkg::result_t  skid_word_reg;
    logic              take;
    logic              fire;

    assign word_ready = !skid_valid_reg;
    assign fire       = word_valid && word_ready;
    assign take       = out_valid_reg && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                if (!out_valid_reg || take)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (take)
            begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (!out_valid_reg || take)
            begin
                out_word_reg <= word;
            end
            else
            begin
                skid_word_reg <= word;
            end
        end
        else if (take && skid_valid_reg)
        begin
            out_word_reg <= skid_word_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = out_word_reg.status;
    assign result.expected_close = out_word_reg.expected_close;
    assign result.token_length   = out_word_reg.token_length;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !result.ready))
        else $error("skid register filled without a stalled output");

endmodule

@@ sv/dollar_bracket_matcher.sv @@
// Dollar token matcher: takes one character word per cycle on stream while the output stage has
// room, and returns exactly one registered result word per character on token, in order.
// A '$' opens a token; an opening bracket right after it starts a bracketed token whose closers
// are tracked on a 64-entry chain of stack cells, so the top is compared combinationally and each
// push or pop is a single shift of the chain. The result channel has a two-word output stage, so
// stream stays ready while one result waits. Status codes: 0 in progress, 1 not dollar, 2 plain
// dollar, 3 bracketed done, 4 unexpected end, 5 mismatch, 6 overflow.
// Depends on dbm_pkg, dbm_ifs, dbm_cell, dbm_stack and dbm_skid.
`timescale 1ns / 1ps

module dollar_bracket_matcher (
    input  logic          clk,
    input  logic          rst_n,
    dbm_char_if.sink      stream,
    dbm_result_if.source  token
);

    dbm_pkg::phase_t               phase_reg;
    dbm_pkg::phase_t               phase_next;
    logic [dbm_pkg::DEPTH_W-1:0]   depth_reg;
    logic [dbm_pkg::DEPTH_W-1:0]   depth_next;
    logic [dbm_pkg::LEN_W-1:0]     len_reg;
    logic [dbm_pkg::LEN_W-1:0]     len_next;
    logic [dbm_pkg::LEN_W-1:0]     len_inc;

    logic                          in_fire;
    logic                          word_ready;
    dbm_pkg::code_t                open_code;
    dbm_pkg::code_t                close_code;
    dbm_pkg::code_t                top_code;
    logic [dbm_pkg::CHAR_W-1:0]    top_ascii;
    dbm_pkg::stack_op_t            op;
    dbm_pkg::result_t              res;

    assign stream.ready = word_ready;
    assign in_fire      = stream.valid && word_ready;

    assign open_code  = dbm_pkg::opener_code(stream.character);
    assign close_code = dbm_pkg::closer_code(stream.character);
    assign top_ascii  = dbm_pkg::closer_ascii(top_code);
    assign len_inc    = (len_reg == dbm_pkg::LEN_MAX) ? len_reg
                                                      : len_reg + dbm_pkg::LEN_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dbm_pkg::PH_IDLE;
            depth_reg <= '0;
            len_reg   <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            depth_reg <= depth_next;
            len_reg   <= len_next;
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        depth_next         = depth_reg;
        len_next           = len_reg;
        op.push            = 1'b0;
        op.pop             = 1'b0;
        op.code            = open_code;
        res.status         = dbm_pkg::ST_BUSY;
        res.expected_close = dbm_pkg::CH_NUL;
        res.token_length   = len_reg;

        case (phase_reg)
            dbm_pkg::PH_DOLLAR:
            begin
                if (stream.end_of_input || open_code == dbm_pkg::CODE_NONE)
                begin
                    res.status = dbm_pkg::ST_PLAIN;
                    phase_next = dbm_pkg::PH_IDLE;
                    depth_next = '0;
                    len_next   = '0;
                end
                else
                begin
                    op.push          = in_fire;
                    depth_next       = dbm_pkg::DEPTH_W'(1);
                    len_next         = len_inc;
                    phase_next       = dbm_pkg::PH_BRACKET;
                    res.token_length = len_inc;
                end
            end

            dbm_pkg::PH_BRACKET:
            begin
                if (stream.end_of_input)
                begin
                    res.status         = dbm_pkg::ST_EOF;
                    res.expected_close = top_ascii;
                    phase_next         = dbm_pkg::PH_IDLE;
                    depth_next         = '0;
                    len_next           = '0;
                end
                else
                begin
                    res.token_length = len_inc;
                    len_next         = len_inc;
                    if (open_code != dbm_pkg::CODE_NONE)
                    begin
                        if (depth_reg == dbm_pkg::DEPTH_W'(dbm_pkg::STACK_DEPTH))
                        begin
                            res.status         = dbm_pkg::ST_OVERFLOW;
                            res.expected_close = top_ascii;
                            phase_next         = dbm_pkg::PH_IDLE;
                            depth_next         = '0;
                            len_next           = '0;
                        end
                        else
                        begin
                            op.push    = in_fire;
                            depth_next = depth_reg + dbm_pkg::DEPTH_W'(1);
                        end
                    end
                    else if (close_code != dbm_pkg::CODE_NONE)
                    begin
                        if (close_code != top_code)
                        begin
                            res.status         = dbm_pkg::ST_MISMATCH;
                            res.expected_close = top_ascii;
                            phase_next         = dbm_pkg::PH_IDLE;
                            depth_next         = '0;
                            len_next           = '0;
                        end
                        else if (depth_reg == dbm_pkg::DEPTH_W'(1))
                        begin
                            res.status = dbm_pkg::ST_BRACKETED;
                            phase_next = dbm_pkg::PH_IDLE;
                            depth_next = '0;
                            len_next   = '0;
                        end
                        else
                        begin
                            op.pop     = in_fire;
                            depth_next = depth_reg - dbm_pkg::DEPTH_W'(1);
                        end
                    end
                end
            end

            default:
            begin
                // idle, and the unused phase code
                depth_next = '0;
                if (!stream.end_of_input && stream.character == dbm_pkg::CH_DOLLAR)
                begin
                    phase_next       = dbm_pkg::PH_DOLLAR;
                    len_next         = dbm_pkg::LEN_W'(1);
                    res.token_length = dbm_pkg::LEN_W'(1);
                end
                else
                begin
                    phase_next       = dbm_pkg::PH_IDLE;
                    len_next         = '0;
                    res.status       = dbm_pkg::ST_NOT_DOLLAR;
                    res.token_length = '0;
                end
            end
        endcase
    end

    dbm_stack u_stack (
        .clk (clk),
        .op  (op),
        .top (top_code)
    );

    dbm_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (stream.valid),
        .word       (res),
        .word_ready (word_ready),
        .result     (token)
    );

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= dbm_pkg::DEPTH_W'(dbm_pkg::STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_depth_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == dbm_pkg::PH_BRACKET) == (depth_reg != '0))
        else $error("stack depth disagrees with phase");

    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && res.status != dbm_pkg::ST_BUSY |=> phase_reg == dbm_pkg::PH_IDLE
            && depth_reg == '0 && len_reg == '0)
        else $error("token ended without returning to idle");

endmodule
